@@ design/hfbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hfbp_pkg;

  // Register reset values and default frame size
  localparam logic [7:0] TIME_HEADER_RST   = 8'hAA;
  localparam logic [7:0] DATE_HEADER_RST   = 8'hCC;
  localparam int         PAYLOAD_BYTES_DEF = 3;

  // Configuration register indexes
  localparam logic [0:0] CFG_TIME_HEADER = 1'b0;
  localparam logic [0:0] CFG_DATE_HEADER = 1'b1;

  // Frame kind codes
  localparam logic KIND_TIME = 1'b0;
  localparam logic KIND_DATE = 1'b1;

  // Parser state
  typedef enum logic [1:0] {
    ST_HUNT = 2'd0,
    ST_TIME = 2'd1,
    ST_DATE = 2'd2
  } parse_state_t;

endpackage

`default_nettype wire

@@ design/header_framed_byte_packet_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A frame's result is registered: it is valid in the cycle after its checksum byte transfer.
// Throughput: one byte per cycle while in_ready is high; the byte path is a single registered update.
// A result held by a low out_ready keeps in_ready low until it drains.
// Reset (rst, synchronous): back to hunting, result register empty,
// headers reload to 0xAA (time) and 0xCC (date).

module header_framed_byte_packet_parser_core #(
  parameter int PAYLOAD_BYTES = hfbp_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_wr_en,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  // byte input
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  // frame result
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            frame_kind,
  output logic [7:0]      first_byte,
  output logic [7:0]      second_byte,
  output logic [7:0]      third_byte,
  output logic            sum_ok
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [7:0]             time_header;
  logic [7:0]             date_header;
  hfbp_pkg::parse_state_t state, state_next;
  logic [CNT_W-1:0]       byte_count, byte_count_next;
  logic [7:0]             running_sum, running_sum_next;
  logic [7:0]             payload [PAYLOAD_BYTES];
  logic                   in_fire;
  logic                   collect;
  logic                   emit;
  logic [7:0]             pay0, pay1, pay2;

  // Header registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_header <= hfbp_pkg::TIME_HEADER_RST;
      date_header <= hfbp_pkg::DATE_HEADER_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == hfbp_pkg::CFG_TIME_HEADER) time_header <= cfg_data;
      if (cfg_index == hfbp_pkg::CFG_DATE_HEADER) date_header <= cfg_data;
    end
  end

  // Accept a byte whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Next state, counters and sum
  always_comb begin
    state_next       = state;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    collect          = 1'b0;
    emit             = 1'b0;
    if (in_fire) begin
      unique case (state)
        hfbp_pkg::ST_TIME, hfbp_pkg::ST_DATE: begin
          if (byte_count < CNT_W'(PAYLOAD_BYTES)) begin
            collect          = 1'b1;
            byte_count_next  = byte_count + CNT_W'(1);
            running_sum_next = running_sum + rx_byte;
          end else begin
            // checksum byte closes the frame
            emit             = 1'b1;
            state_next       = hfbp_pkg::ST_HUNT;
            byte_count_next  = '0;
            running_sum_next = '0;
          end
        end
        default: begin
          // hunting: time header wins when both headers match
          if (rx_byte == time_header)      state_next = hfbp_pkg::ST_TIME;
          else if (rx_byte == date_header) state_next = hfbp_pkg::ST_DATE;
          else                             state_next = hfbp_pkg::ST_HUNT;
          byte_count_next  = '0;
          running_sum_next = '0;
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hfbp_pkg::ST_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      state       <= state_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // Payload byte store
  always_ff @(posedge clk) begin
    if (collect) payload[byte_count[IDX_W-1:0]] <= rx_byte;
  end

  // Output taps; bytes beyond the frame size read as zero
  assign pay0 = payload[0];
  generate
    if (PAYLOAD_BYTES > 1) begin : g_pay1
      assign pay1 = payload[1];
    end else begin : g_no_pay1
      assign pay1 = '0;
    end
    if (PAYLOAD_BYTES > 2) begin : g_pay2
      assign pay2 = payload[2];
    end else begin : g_no_pay2
      assign pay2 = '0;
    end
  endgenerate

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_kind  <= (state == hfbp_pkg::ST_DATE) ? hfbp_pkg::KIND_DATE
                                                  : hfbp_pkg::KIND_TIME;
      first_byte  <= pay0;
      second_byte <= pay1;
      third_byte  <= pay2;
      sum_ok      <= (running_sum == rx_byte);
    end
  end

  // Checks
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte taken while result stalled");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && state != hfbp_pkg::ST_HUNT))
    else $error("result without a closing checksum byte");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(PAYLOAD_BYTES))
    else $error("byte count past frame size");

  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    state == hfbp_pkg::ST_HUNT |-> byte_count == '0 && running_sum == '0)
    else $error("frame state not cleared while hunting");

endmodule

`default_nettype wire
